/* rtl/hmm_pkg.sv */
// Shared types, constants and microcode table for the histogram matching map.
package hmm_pkg;

  localparam int NUM_BINS = 64;
  localparam int BIN_W    = 6;
  localparam int PROP_W   = 16;
  localparam int SUM_W    = PROP_W + BIN_W;
  localparam int OP_W     = 2;

  localparam logic [BIN_W-1:0] END_BIN = BIN_W'(NUM_BINS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_REF = 2'd0,
    OP_LOAD_CUR = 2'd1,
    OP_COMPUTE  = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STEP_IDLE = 3'd0,
    STEP_INIT = 3'd1,
    STEP_READ = 3'd2,
    STEP_WALK = 3'd3,
    STEP_FIN  = 3'd4
  } step_t;

  typedef enum logic [1:0] {
    COND_NEXT  = 2'd0,
    COND_GOTO  = 2'd1,
    COND_START = 2'd2,
    COND_DONE  = 2'd3
  } cond_t;

  // One microcode word: datapath controls plus sequencing.
  typedef struct packed {
    logic  busy;
    logic  clear;
    logic  walk;
    logic  fin;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // Status returned from datapath to the sequencer.
  typedef struct packed {
    logic start_compute;
    logic at_end;
  } stat_t;

  function automatic ctrl_t hmm_ucode(input step_t step);
    ctrl_t cw;
    cw = '{busy: 1'b0, clear: 1'b0, walk: 1'b0, fin: 1'b0,
           cond: COND_GOTO, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        cw.cond   = COND_START;
        cw.target = STEP_INIT;
      end
      STEP_INIT: begin
        cw.busy  = 1'b1;
        cw.clear = 1'b1;
        cw.cond  = COND_NEXT;
      end
      STEP_READ: begin
        cw.busy   = 1'b1;
        cw.cond   = COND_DONE;
        cw.target = STEP_FIN;
      end
      STEP_WALK: begin
        cw.busy   = 1'b1;
        cw.walk   = 1'b1;
        cw.cond   = COND_GOTO;
        cw.target = STEP_READ;
      end
      STEP_FIN: begin
        cw.busy   = 1'b1;
        cw.fin    = 1'b1;
        cw.cond   = COND_GOTO;
        cw.target = STEP_IDLE;
      end
      default: begin
        cw.busy   = 1'b1;
        cw.cond   = COND_GOTO;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

/* rtl/hmm_ram.sv */
// Generic simple dual-port RAM with registered read.
module hmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/hmm_seq.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
module hmm_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  hmm_pkg::stat_t stat,
  output hmm_pkg::ctrl_t ctrl
);

  hmm_pkg::step_t step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= hmm_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    ctrl = hmm_pkg::hmm_ucode(step_r);
    unique case (ctrl.cond)
      hmm_pkg::COND_NEXT:  step_nxt = hmm_pkg::step_t'(step_r + 3'd1);
      hmm_pkg::COND_GOTO:  step_nxt = ctrl.target;
      hmm_pkg::COND_START: step_nxt = stat.start_compute ? ctrl.target : step_r;
      hmm_pkg::COND_DONE:  step_nxt = stat.at_end ? ctrl.target
                                                  : hmm_pkg::step_t'(step_r + 3'd1);
      default:             step_nxt = hmm_pkg::STEP_IDLE;
    endcase
  end

  // The walk step always returns to the read step.
  a_walk_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == hmm_pkg::STEP_WALK |=> step_r == hmm_pkg::STEP_READ)
    else $error("walk step did not return to read step");

  // A compute start leaves idle at once.
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == hmm_pkg::STEP_IDLE && stat.start_compute |=> step_r == hmm_pkg::STEP_INIT)
    else $error("compute start not taken");

  // Finish is entered only with both indices at the last bin.
  a_fin_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == hmm_pkg::STEP_FIN |-> $past(stat.at_end))
    else $error("finish reached before end of walk");

endmodule

/* rtl/hmm_dp.sv */
// Datapath: bin stores, walk indices, running sums and result register.
module hmm_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hmm_pkg::ctrl_t             ctrl,
  output hmm_pkg::stat_t             stat,
  input  logic                       start,
  input  logic [hmm_pkg::OP_W-1:0]   in_operation,
  input  logic [hmm_pkg::BIN_W-1:0]  in_bin_index,
  input  logic [hmm_pkg::PROP_W-1:0] in_proportion,
  output logic                       out_valid,
  output logic [hmm_pkg::BIN_W-1:0]  out_current_bin,
  output logic [hmm_pkg::BIN_W-1:0]  out_mapped_bin,
  output logic                       out_last
);

  logic                       take;
  logic                       idx_ok;
  logic                       we_ref, we_cur;
  logic [hmm_pkg::PROP_W-1:0] ref_rd, cur_rd;

  logic [hmm_pkg::BIN_W-1:0] c_r, c_nxt, p_r, p_nxt;
  logic [hmm_pkg::SUM_W-1:0] sc_r, sc_nxt, sp_r, sp_nxt;
  logic                      c_last, p_last, lt, gt, adv_c, adv_p;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_last_r, out_last_nxt;
  logic [hmm_pkg::BIN_W-1:0] out_cur_r, out_cur_nxt, out_map_r, out_map_nxt;

  assign take   = start && !ctrl.busy;
  assign idx_ok = {1'b0, in_bin_index} < (hmm_pkg::BIN_W+1)'(hmm_pkg::NUM_BINS);
  assign we_ref = take && idx_ok && (in_operation == hmm_pkg::OP_LOAD_REF);
  assign we_cur = take && idx_ok && (in_operation == hmm_pkg::OP_LOAD_CUR);

  assign stat.start_compute = take && (in_operation == hmm_pkg::OP_COMPUTE);
  assign stat.at_end        = c_last && p_last;

  hmm_ram #(.WIDTH(hmm_pkg::PROP_W), .DEPTH(hmm_pkg::NUM_BINS)) u_ref_ram (
    .clk   (clk),
    .we    (we_ref),
    .waddr (in_bin_index[$clog2(hmm_pkg::NUM_BINS)-1:0]),
    .wdata (in_proportion),
    .raddr (p_r[$clog2(hmm_pkg::NUM_BINS)-1:0]),
    .rdata (ref_rd)
  );

  hmm_ram #(.WIDTH(hmm_pkg::PROP_W), .DEPTH(hmm_pkg::NUM_BINS)) u_cur_ram (
    .clk   (clk),
    .we    (we_cur),
    .waddr (in_bin_index[$clog2(hmm_pkg::NUM_BINS)-1:0]),
    .wdata (in_proportion),
    .raddr (c_r[$clog2(hmm_pkg::NUM_BINS)-1:0]),
    .rdata (cur_rd)
  );

  assign c_last = (c_r == hmm_pkg::END_BIN);
  assign p_last = (p_r == hmm_pkg::END_BIN);
  assign lt     = sc_r < sp_r;
  assign gt     = sc_r > sp_r;

  always_comb begin
    priority if (lt) begin
      adv_c = !c_last;
      adv_p = c_last;
    end else if (gt) begin
      adv_c = p_last;
      adv_p = !p_last;
    end else begin
      adv_c = !c_last;
      adv_p = !p_last;
    end
  end

  always_comb begin
    c_nxt         = c_r;
    p_nxt         = p_r;
    sc_nxt        = sc_r;
    sp_nxt        = sp_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    out_cur_nxt   = out_cur_r;
    out_map_nxt   = out_map_r;
    if (ctrl.clear) begin
      c_nxt  = '0;
      p_nxt  = '0;
      sc_nxt = '0;
      sp_nxt = '0;
    end
    if (ctrl.walk) begin
      // Entry for c is final once c moves on; it maps to the current p.
      if (adv_c) begin
        c_nxt         = c_r + hmm_pkg::BIN_W'(1);
        sc_nxt        = sc_r + hmm_pkg::SUM_W'(cur_rd);
        out_valid_nxt = 1'b1;
        out_cur_nxt   = c_r;
        out_map_nxt   = p_r;
      end
      if (adv_p) begin
        p_nxt  = p_r + hmm_pkg::BIN_W'(1);
        sp_nxt = sp_r + hmm_pkg::SUM_W'(ref_rd);
      end
    end
    if (ctrl.fin) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      out_cur_nxt   = hmm_pkg::END_BIN;
      out_map_nxt   = hmm_pkg::END_BIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r         <= '0;
      p_r         <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      c_r         <= c_nxt;
      p_r         <= p_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sc_r      <= sc_nxt;
    sp_r      <= sp_nxt;
    out_cur_r <= out_cur_nxt;
    out_map_r <= out_map_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_last        = out_last_r;
  assign out_current_bin = out_cur_r;
  assign out_mapped_bin  = out_map_r;

  // The last entry always maps the final bin onto the final reference bin.
  a_last_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |->
      out_cur_r == hmm_pkg::END_BIN && out_map_r == hmm_pkg::END_BIN)
    else $error("last entry not end to end");

  // A walk step never moves c beyond the last current bin.
  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.walk && adv_c && !ctrl.clear |-> c_r != hmm_pkg::END_BIN)
    else $error("walk advanced past last current bin");

  // Loads never happen while a compute is running.
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (we_ref || we_cur) |-> !ctrl.busy)
    else $error("bin store written during compute");

endmodule

/* rtl/histogram_matching_map.sv */
// Top level of the histogram matching map: sequencer plus datapath.
//
//  channel  ports                                           handshake
//  -------  ----------------------------------------------  ---------------------------
//  in       in_operation, in_bin_index, in_proportion       start && !busy
//  out      out_current_bin, out_mapped_bin, out_last       out_valid, one cycle, no hold
//
// Steps: a load item produces no result. A compute item runs init, then S
//   read/walk pairs, S the number of walk steps (at most 2*(NUM_BINS-1)),
//   then a final read and the finish step; each walk step is a RAM read
//   (registered read of both bin stores) followed by a compare/update step.
// Results: one per current bin, in bin order, emitted when the walk moves past
//   that bin; the last bin's entry comes from the finish step with out_last set.
// Reset: synchronous, active low; clears the step counter, indices and strobe.
//   Bin stores are not cleared and must be loaded before compute.
// Stalls: busy is high from the cycle after a compute start until the finish
//   step is done; results cannot be held off by the receiver.
module histogram_matching_map (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [hmm_pkg::OP_W-1:0]   in_operation,
  input  logic [hmm_pkg::BIN_W-1:0]  in_bin_index,
  input  logic [hmm_pkg::PROP_W-1:0] in_proportion,
  output logic                       out_valid,
  output logic [hmm_pkg::BIN_W-1:0]  out_current_bin,
  output logic [hmm_pkg::BIN_W-1:0]  out_mapped_bin,
  output logic                       out_last
);

  hmm_pkg::ctrl_t ctrl;
  hmm_pkg::stat_t stat;

  // Microcode sequencer: idle, init, then read/walk pairs, a last read, then finish.
  hmm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Datapath: loads go straight into the bin stores while idle.
  hmm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .start           (start),
    .in_operation    (in_operation),
    .in_bin_index    (in_bin_index),
    .in_proportion   (in_proportion),
    .out_valid       (out_valid),
    .out_current_bin (out_current_bin),
    .out_mapped_bin  (out_mapped_bin),
    .out_last        (out_last)
  );

  assign busy = ctrl.busy;

endmodule
